@@ hdl/ffba_pkg.sv @@
// ----------------------------------------------------------------------------
// ffba_pkg - shared types and constants of the first-fit block allocator
// Block table geometry, entry record, status codes and sequencer states.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int MemBytes  = 16384;
  localparam int HdrBytes  = 24;
  localparam int MaxBlocks = 64;
  localparam int IdxW      = $clog2(MaxBlocks);
  localparam int CntW      = IdxW + 1;
  localparam int StartW    = 14;
  localparam int SizeW     = 15;

  typedef struct packed {
    logic [StartW-1:0] start;
    logic [SizeW-1:0]  size;
    logic              free;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  localparam entry_t ResetEntry = '{start: '0, size: SizeW'(MemBytes - HdrBytes), free: 1'b1};

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StNoFit    = 2'd1,
    StBadOfs   = 2'd2,
    StTblFull  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_SPLIT_HI,
    S_SPLIT_LO,
    S_COAL_RD,
    S_COAL_CHK,
    S_COAL_END,
    S_DONE
  } state_e;

endpackage

@@ hdl/ffba_ram.sv @@
// ----------------------------------------------------------------------------
// ffba_ram - generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ffba_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hdl/first_fit_block_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_block_allocator - first-fit allocator with coalescing
// Keeps an address-ordered block table in RAM and serves allocate/free.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with action_i, request_size_i and block_offset_i; the request
//   is taken when start is high and busy is low. busy stays high until the
//   result has been shown. The result appears on status_o and
//   granted_offset_o for exactly one cycle with done_o high; the receiver
//   cannot stall it.
//   Sequencing: each table entry visited takes a read and a check state on
//   the single RAM read port (address, then registered data). Allocate of
//   entry i in a table of n entries scans 0..i, then a split shifts the
//   entries above i up by one and writes both halves. Free of entry i scans
//   0..i, then merges in a pass over all n entries. A miss scans all n.
//   Worst case is a free of the last of 64 entries. One request at a time.
//   Reset: the table holds one free block at offset 0 spanning the memory
//   less one header; no clearing pass is needed.
// ----------------------------------------------------------------------------
module first_fit_block_allocator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic                       action_i,
  input  logic [ffba_pkg::SizeW-1:0]  request_size_i,
  input  logic [ffba_pkg::StartW-1:0] block_offset_i,
  output logic                       done_o,
  output logic [1:0]                 status_o,
  output logic [ffba_pkg::StartW-1:0] granted_offset_o
);
  import ffba_pkg::*;

  state_e state_q, state_d;

  logic              act_q, act_d;
  logic [SizeW-1:0]  req_q, req_d;
  logic [StartW-1:0] off_q, off_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [IdxW-1:0]   j_q, j_d;
  logic [IdxW-1:0]   w_q, w_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  entry_t            fnd_q, fnd_d;
  entry_t            wrec_q, wrec_d;
  logic              e0_wr_q, e0_wr_d;
  logic [IdxW-1:0]   raddr_q;
  status_e           status_q, status_d;
  logic [StartW-1:0] grant_q, grant_d;

  logic              we;
  logic [IdxW-1:0]   waddr, raddr;
  entry_t            wdata;
  logic [EntryW-1:0] ram_rdata;
  entry_t            rec, crec;

  logic              hit, last, split_ok, coal_last, do_shift;
  logic [SizeW-1:0]  rem;

  ffba_ram #(.Width(EntryW), .Depth(MaxBlocks)) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  // entry 0 reads as its reset value until first written
  assign rec = (raddr_q == '0 && !e0_wr_q) ? ResetEntry : entry_t'(ram_rdata);

  always_comb begin
    crec = rec;
    if (raddr_q == idx_q) begin
      crec.free = 1'b1;
    end
  end

  assign rem       = rec.size - req_q;
  assign hit       = act_q ? (rec.start == off_q) : (rec.free && rec.size >= req_q);
  assign last      = (CntW'(idx_q) + CntW'(1)) == cnt_q;
  assign split_ok  = !(rem < SizeW'(HdrBytes));
  assign coal_last = (CntW'(raddr_q) + CntW'(1)) == cnt_q;
  assign do_shift  = CntW'(j_q) > (CntW'(idx_q) + CntW'(1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:     if (start) state_d = S_SCAN_RD;
      S_SCAN_RD:  state_d = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (hit) begin
          if (act_q) state_d = S_COAL_RD;
          else if (!split_ok || cnt_q >= CntW'(MaxBlocks)) state_d = S_DONE;
          else state_d = S_SHIFT_RD;
        end else if (last) begin
          state_d = S_DONE;
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: state_d = do_shift ? S_SHIFT_WR : S_SPLIT_HI;
      S_SHIFT_WR: state_d = S_SHIFT_RD;
      S_SPLIT_HI: state_d = S_SPLIT_LO;
      S_SPLIT_LO: state_d = S_DONE;
      S_COAL_RD:  state_d = S_COAL_CHK;
      S_COAL_CHK: state_d = coal_last ? S_COAL_END : S_COAL_RD;
      S_COAL_END: state_d = S_DONE;
      S_DONE:     state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    act_d    = act_q;
    req_d    = req_q;
    off_d    = off_q;
    idx_d    = idx_q;
    j_d      = j_q;
    w_d      = w_q;
    cnt_d    = cnt_q;
    fnd_d    = fnd_q;
    wrec_d   = wrec_q;
    status_d = status_q;
    grant_d  = grant_q;
    we       = 1'b0;
    waddr    = idx_q;
    wdata    = rec;
    raddr    = idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          act_d    = action_i;
          req_d    = request_size_i;
          off_d    = block_offset_i;
          idx_d    = '0;
          j_d      = cnt_q[IdxW-1:0];
          status_d = action_i ? StBadOfs : StNoFit;
          grant_d  = '0;
        end
      end
      S_SCAN_CHK: begin
        fnd_d = rec;
        if (hit) begin
          if (act_q) begin
            status_d = StOk;
            w_d      = '0;
          end else if (!split_ok) begin
            we         = 1'b1;
            wdata      = rec;
            wdata.free = 1'b0;
            status_d   = StOk;
            grant_d    = rec.start;
          end else if (cnt_q >= CntW'(MaxBlocks)) begin
            status_d = StTblFull;
          end
        end else if (!last) begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      S_SHIFT_RD: raddr = j_q - IdxW'(1);
      S_SHIFT_WR: begin
        we    = 1'b1;
        waddr = j_q;
        wdata = rec;
        j_d   = j_q - IdxW'(1);
      end
      S_SPLIT_HI: begin
        we         = 1'b1;
        waddr      = idx_q + IdxW'(1);
        wdata.start = StartW'(fnd_q.start + StartW'(HdrBytes) + StartW'(req_q));
        wdata.size = SizeW'(fnd_q.size - req_q - SizeW'(HdrBytes));
        wdata.free = 1'b1;
      end
      S_SPLIT_LO: begin
        we         = 1'b1;
        wdata.start = fnd_q.start;
        wdata.size = req_q;
        wdata.free = 1'b0;
        cnt_d      = cnt_q + CntW'(1);
        status_d   = StOk;
        grant_d    = fnd_q.start;
      end
      S_COAL_RD: raddr = j_q;
      S_COAL_CHK: begin
        j_d = j_q + IdxW'(1);
        if (raddr_q == '0) begin
          wrec_d = crec;
        end else if (wrec_q.free && crec.free) begin
          // merge into the block being built
          wrec_d.size = SizeW'(wrec_q.size + crec.size + SizeW'(HdrBytes));
        end else begin
          we     = 1'b1;
          waddr  = w_q;
          wdata  = wrec_q;
          w_d    = w_q + IdxW'(1);
          wrec_d = crec;
        end
      end
      S_COAL_END: begin
        we    = 1'b1;
        waddr = w_q;
        wdata = wrec_q;
        cnt_d = CntW'(w_q) + CntW'(1);
      end
      default: ;
    endcase
    // the merge pass walks from entry 0 with j as its read index
    if (state_q == S_SCAN_CHK && hit && act_q) begin
      j_d = '0;
    end
  end

  assign e0_wr_d = e0_wr_q | (we && waddr == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= CntW'(1);
      e0_wr_q  <= 1'b0;
      status_q <= StOk;
      grant_q  <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      e0_wr_q  <= e0_wr_d;
      status_q <= status_d;
      grant_q  <= grant_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q   <= act_d;
    req_q   <= req_d;
    off_q   <= off_d;
    idx_q   <= idx_d;
    j_q     <= j_d;
    w_q     <= w_d;
    fnd_q   <= fnd_d;
    wrec_q  <= wrec_d;
    raddr_q <= raddr;
  end

  assign busy             = state_q != S_IDLE;
  assign done_o           = state_q == S_DONE;
  assign status_o         = status_q;
  assign granted_offset_o = grant_q;

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q >= CntW'(1) && cnt_q <= CntW'(MaxBlocks))
    else $error("block count out of range");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy && !done_o)
    else $error("accepted request did not raise busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy)
    else $error("result strobe longer than one cycle");

  a_grant_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != StOk |-> granted_offset_o == '0)
    else $error("offset granted on failed request");
`endif

endmodule
